// ===== rtl/core/sti_pkg.sv =====
// Package for the segment/triangle intersection core: item types and widths
package sti_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int DIV_BITS = 32;
	localparam int DIST_W = 42;

	typedef struct packed {
		logic [63:0] plane_packed;
		logic [47:0] vertex_c;
		logic [47:0] vertex_b;
		logic [47:0] vertex_a;
		logic [47:0] end_point;
		logic [47:0] start_point;
	} sti_in_t;

	typedef struct packed {
		logic [15:0]        fraction;
		logic signed [15:0] cross_z;
		logic signed [15:0] cross_y;
		logic signed [15:0] cross_x;
		logic               hit;
	} sti_out_t;

endpackage

// ===== rtl/core/segment_triangle_intersect_core.sv =====
// Segment/triangle intersection core: pipelined distance, divide, point and edge tests
//
// Usage: one query item enters on in_valid/in_stall and one result item leaves on
// out_valid/out_stall. The stage chain is: plane distances (2 stages), a
// restoring divider with one quotient bit per stage (32 stages), crossing point
// multiply (1 stage), edge differences (1 stage), edge cross products (1 stage),
// and a registered result.
// Throughput: one item per cycle while out_stall is low; every stage holds one item and advances
// whenever the stage ahead is free, so the rate is set by the divider chain
// being fully pipelined.
// Reset clears every stage valid bit; payload registers are not reset.
// When out_stall is high the output item holds; bubbles ahead are squeezed out,
// and in_stall rises only when the first stage is full and cannot move.
module segment_triangle_intersect_core #(
	parameter int COORD_BITS = sti_pkg::COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  sti_pkg::sti_in_t in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output sti_pkg::sti_out_t out_item
);
	import sti_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int XW = 3 * CB;
	localparam int NS = 38;
	localparam int DIFF_W = CB + 1;
	localparam int OFF_W = CB + 1;
	localparam int U_W = CB + 2;
	localparam int CP_W = 2 * U_W + 1;
	localparam int DW = 3 * CB + 20;

	typedef logic signed [CB-1:0] crd_t;
	typedef crd_t [2:0] vec_t;

	// bits above the three fields are ignored, missing bits read as zero
	function automatic vec_t unpack(input logic [47:0] w);
		vec_t v;
		logic [XW-1:0] wx;
		wx = XW'(w);
		for (int k = 0; k < 3; k++) v[k] = wx[k*CB +: CB];
		return v;
	endfunction

	// Stage control: stage i advances when stage i+1 is free or moving
	logic [NS-1:0] vld_q;
	logic [NS:0]   adv;
	always_comb begin
		adv[NS] = !out_stall;
		for (int i = NS - 1; i >= 0; i--) adv[i] = !vld_q[i] || adv[i+1];
	end
	assign in_stall = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < NS; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Common payload carried along the chain
	typedef struct packed {
		vec_t p0;
		vec_t p1;
		vec_t va;
		vec_t vb;
		vec_t vc;
		logic [2:0] mask;
	} geo_t;

	// s1: products N.P
	vec_t sp_c, ep_c;
	assign sp_c = unpack(in_item.start_point);
	assign ep_c = unpack(in_item.end_point);

	geo_t geo_s1;
	logic signed [DW-1:0] dn_s1;
	logic signed [CB+16:0] pr0_s1 [3];
	logic signed [CB+16:0] pr1_s1 [3];
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			geo_s1.p0 <= sp_c;
			geo_s1.p1 <= ep_c;
			geo_s1.va <= unpack(in_item.vertex_a);
			geo_s1.vb <= unpack(in_item.vertex_b);
			geo_s1.vc <= unpack(in_item.vertex_c);
			for (int k = 0; k < 3; k++) begin
				geo_s1.mask[k] <= ($signed(in_item.plane_packed[16*k +: 16]) > 17'sd2048) ||
					($signed(in_item.plane_packed[16*k +: 16]) < -17'sd2048);
				pr0_s1[k] <= $signed(in_item.plane_packed[16*k +: 16]) * sp_c[k];
				pr1_s1[k] <= $signed(in_item.plane_packed[16*k +: 16]) * ep_c[k];
			end
			dn_s1 <= DW'($signed(in_item.plane_packed[63:48])) <<< 12;
		end
	end

	// s2: distances, sign test, divider setup
	geo_t geo_s2;
	logic cross_s2;
	logic [DW-1:0] num_s2, den_s2;
	logic signed [DW-1:0] d0_c, d1_c, dd_c;
	always_comb begin
		d0_c = dn_s1 - DW'(pr0_s1[0]) - DW'(pr0_s1[1]) - DW'(pr0_s1[2]);
		d1_c = dn_s1 - DW'(pr1_s1[0]) - DW'(pr1_s1[1]) - DW'(pr1_s1[2]);
		dd_c = d0_c - d1_c;
	end
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			geo_s2 <= geo_s1;
			cross_s2 <= !((d0_c > 0 && d1_c > 0) || (d0_c < 0 && d1_c < 0) ||
				(d0_c == 0 && d1_c == 0));
			num_s2 <= d0_c[DW-1] ? DW'(-d0_c) : DW'(d0_c);
			den_s2 <= dd_c[DW-1] ? DW'(-dd_c) : DW'(dd_c);
		end
	end

	// s3..s34: one quotient bit per stage
	geo_t          geo_dv [DIV_BITS+1];
	logic          crs_dv [DIV_BITS+1];
	logic          full_dv [DIV_BITS+1];
	logic [DW-1:0] rem_dv [DIV_BITS+1];
	logic [DW-1:0] den_dv [DIV_BITS+1];
	logic [DIV_BITS-1:0] q_dv [DIV_BITS+1];
	always_comb begin
		geo_dv[0] = geo_s2;
		crs_dv[0] = cross_s2;
		full_dv[0] = num_s2 >= den_s2;
		rem_dv[0] = num_s2;
		den_dv[0] = den_s2;
		q_dv[0] = '0;
	end
	for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
		logic [DW:0] sh;
		assign sh = {rem_dv[g], 1'b0};
		always_ff @(posedge clk) begin
			if (adv[2+g]) begin
				geo_dv[g+1] <= geo_dv[g];
				crs_dv[g+1] <= crs_dv[g];
				full_dv[g+1] <= full_dv[g];
				den_dv[g+1] <= den_dv[g];
				if (sh >= {1'b0, den_dv[g]}) begin
					rem_dv[g+1] <= DW'(sh - {1'b0, den_dv[g]});
					q_dv[g+1] <= {q_dv[g][DIV_BITS-2:0], 1'b1};
				end else begin
					rem_dv[g+1] <= DW'(sh);
					q_dv[g+1] <= {q_dv[g][DIV_BITS-2:0], 1'b0};
				end
			end
		end
	end

	// s35: crossing point
	localparam int LD = DIV_BITS + 2;
	logic [DIV_BITS:0] t_c;
	assign t_c = full_dv[DIV_BITS] ? {1'b1, {DIV_BITS{1'b0}}} : {1'b0, q_dv[DIV_BITS]};
	geo_t geo_s35;
	logic crs_s35;
	logic [15:0] frac_s35;
	logic signed [CB+1:0] pt_s35 [3];
	always_ff @(posedge clk) begin
		if (adv[LD]) begin
			geo_s35 <= geo_dv[DIV_BITS];
			crs_s35 <= crs_dv[DIV_BITS];
			frac_s35 <= 16'((34'(t_c) + 34'd65536) >> 17);
			for (int k = 0; k < 3; k++) begin
				logic signed [DIFF_W-1:0] df;
				logic [DIFF_W-1:0] mg;
				logic [DIFF_W+DIV_BITS:0] pm;
				logic [OFF_W-1:0] off;
				df = DIFF_W'(geo_dv[DIV_BITS].p1[k]) - DIFF_W'(geo_dv[DIV_BITS].p0[k]);
				mg = df[DIFF_W-1] ? DIFF_W'(-df) : DIFF_W'(df);
				pm = mg * t_c + (DIFF_W+DIV_BITS+1)'(64'h8000_0000);
				off = OFF_W'(pm >> DIV_BITS);
				pt_s35[k] <= df[DIFF_W-1] ?
					(CB+2)'(geo_dv[DIV_BITS].p0[k]) - (CB+2)'(off) :
					(CB+2)'(geo_dv[DIV_BITS].p0[k]) + (CB+2)'(off);
			end
		end
	end

	// s36: edge vectors
	typedef logic signed [U_W-1:0] u_t;
	u_t u_s36 [3][3];
	u_t e_s36 [3][3];
	logic [2:0] mask_s36;
	logic crs_s36;
	logic [15:0] frac_s36;
	logic signed [CB+1:0] pt_s36 [3];
	always_ff @(posedge clk) begin
		if (adv[LD+1]) begin
			mask_s36 <= geo_s35.mask;
			crs_s36 <= crs_s35;
			frac_s36 <= frac_s35;
			pt_s36 <= pt_s35;
			for (int k = 0; k < 3; k++) begin
				u_s36[0][k] <= U_W'(pt_s35[k]) - U_W'(geo_s35.va[k]);
				u_s36[1][k] <= U_W'(pt_s35[k]) - U_W'(geo_s35.vb[k]);
				u_s36[2][k] <= U_W'(pt_s35[k]) - U_W'(geo_s35.vc[k]);
				e_s36[0][k] <= U_W'(geo_s35.vb[k]) - U_W'(geo_s35.va[k]);
				e_s36[1][k] <= U_W'(geo_s35.vc[k]) - U_W'(geo_s35.vb[k]);
				e_s36[2][k] <= U_W'(geo_s35.va[k]) - U_W'(geo_s35.vc[k]);
			end
		end
	end

	// s37: cross product signs
	logic [2:0] fl_s37 [3];
	logic crs_s37;
	logic [15:0] frac_s37;
	logic signed [CB+1:0] pt_s37 [3];
	always_ff @(posedge clk) begin
		if (adv[LD+2]) begin
			crs_s37 <= crs_s36;
			frac_s37 <= frac_s36;
			pt_s37 <= pt_s36;
			for (int j = 0; j < 3; j++) begin
				logic signed [CP_W-1:0] c0, c1, c2;
				c0 = CP_W'(u_s36[j][1] * e_s36[j][2]) - CP_W'(u_s36[j][2] * e_s36[j][1]);
				c1 = CP_W'(u_s36[j][2] * e_s36[j][0]) - CP_W'(u_s36[j][0] * e_s36[j][2]);
				c2 = CP_W'(u_s36[j][0] * e_s36[j][1]) - CP_W'(u_s36[j][1] * e_s36[j][0]);
				fl_s37[j] <= {c2[CP_W-1], c1[CP_W-1], c0[CP_W-1]} & mask_s36;
			end
		end
	end

	// s38: result register
	function automatic logic [15:0] sat16(input logic signed [CB+1:0] v);
		if (int'(v) > 32767) return 16'h7fff;
		if (int'(v) < -32768) return 16'h8000;
		return 16'(v);
	endfunction

	always_ff @(posedge clk) begin
		if (adv[LD+3]) begin
			if (crs_s37) begin
				out_item.hit <= (fl_s37[0] == fl_s37[1]) && (fl_s37[0] == fl_s37[2]);
				out_item.cross_x <= sat16(pt_s37[0]);
				out_item.cross_y <= sat16(pt_s37[1]);
				out_item.cross_z <= sat16(pt_s37[2]);
				out_item.fraction <= frac_s37;
			end else begin
				out_item <= '0;
			end
		end
	end
	assign out_valid = vld_q[NS-1];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result item changed under stall");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q) && out_stall)
		else $error("input stalled with a free stage");
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.fraction <= 16'd32768)
		else $error("fraction out of range");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_item))
		else $error("result item has unknown bits");

endmodule

// ===== tb/segment_triangle_intersect_core_test.sv =====
// Testbench for segment_triangle_intersect_core: directed and random queries checked against a predictor
module segment_triangle_intersect_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sti_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int LATENCY = 38;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sti_in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sti_out_t out_item;

	sti_out_t expected_q[$];
	int errors = 0;
	int hits = 0;
	int results_seen = 0;
	int items_sent = 0;
	int cycle = 0;
	int idle_pct = 28;
	int hold_cycles = 0;

	segment_triangle_intersect_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
		.out_item(out_item)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT_CYCLES) begin
			$display("%0t timeout", $time);
			$display("segment_triangle_intersect_core_test: errors");
			$finish;
		end
	end

	function automatic void unpack_point(input logic [47:0] w, output longint p[3]);
		for (int k = 0; k < 3; k++)
			p[k] = longint'($signed(w[k*16 +: 16]));
	endfunction

	function automatic logic [2:0] edge_signs(input longint p[3], input longint a[3],
			input longint b[3]);
		longint u[3], e[3], c[3];
		logic [2:0] f;
		for (int k = 0; k < 3; k++) begin
			u[k] = p[k] - a[k];
			e[k] = b[k] - a[k];
		end
		c[0] = u[1] * e[2] - u[2] * e[1];
		c[1] = u[2] * e[0] - u[0] * e[2];
		c[2] = u[0] * e[1] - u[1] * e[0];
		for (int k = 0; k < 3; k++)
			f[k] = c[k] < 0;
		return f;
	endfunction

	function automatic logic [15:0] clamp16(input longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic sti_out_t predict_crossing(input sti_in_t q);
		longint p0[3], p1[3], va[3], vb[3], vc[3], n[3], pt[3];
		longint d, dist0, dist1, den, diff;
		logic [63:0] num, dmag, t32, mag, off;
		logic [2:0] mask, f1, f2, f3;
		sti_out_t r;
		r = '0;
		unpack_point(q.start_point, p0);
		unpack_point(q.end_point, p1);
		unpack_point(q.vertex_a, va);
		unpack_point(q.vertex_b, vb);
		unpack_point(q.vertex_c, vc);
		for (int k = 0; k < 3; k++)
			n[k] = longint'($signed(q.plane_packed[k*16 +: 16]));
		d = longint'($signed(q.plane_packed[63:48]));
		dist0 = d * 4096 - (n[0] * p0[0] + n[1] * p0[1] + n[2] * p0[2]);
		dist1 = d * 4096 - (n[0] * p1[0] + n[1] * p1[1] + n[2] * p1[2]);
		if ((dist0 > 0 && dist1 > 0) || (dist0 < 0 && dist1 < 0))
			return r;
		if (dist0 == 0 && dist1 == 0)
			return r;
		den = dist0 - dist1;
		num = dist0 < 0 ? -dist0 : dist0;
		dmag = den < 0 ? -den : den;
		if (num >= dmag)
			t32 = 64'd1 << 32;
		else
			t32 = 64'((128'(num) << 32) / 128'(dmag));
		mask = '0;
		for (int k = 0; k < 3; k++) begin
			diff = p1[k] - p0[k];
			mag = diff < 0 ? -diff : diff;
			off = (mag * t32 + (64'd1 << 31)) >> 32;
			pt[k] = diff < 0 ? p0[k] - longint'(off) : p0[k] + longint'(off);
			mask[k] = (n[k] < 0 ? -n[k] : n[k]) > 2048;
		end
		f1 = edge_signs(pt, va, vb) & mask;
		f2 = edge_signs(pt, vb, vc) & mask;
		f3 = edge_signs(pt, vc, va) & mask;
		r.hit = (f1 == f2) && (f1 == f3);
		r.cross_x = clamp16(pt[0]);
		r.cross_y = clamp16(pt[1]);
		r.cross_z = clamp16(pt[2]);
		r.fraction = 16'((t32 + (64'd1 << 16)) >> 17);
		return r;
	endfunction

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < idle_pct);
	end

	always @(posedge clk) begin
		sti_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_q.size() == 0) begin
				errors <= errors + 1;
				$display("%0t unexpected result %p", $time, out_item);
			end else begin
				e = expected_q.pop_front();
				if (out_item.hit) hits <= hits + 1;
				if (out_item.hit !== e.hit)
					$display("%0t hit exp %0b got %0b", $time, e.hit, out_item.hit);
				if (out_item.cross_x !== e.cross_x)
					$display("%0t cross_x exp %0d got %0d", $time, e.cross_x, out_item.cross_x);
				if (out_item.cross_y !== e.cross_y)
					$display("%0t cross_y exp %0d got %0d", $time, e.cross_y, out_item.cross_y);
				if (out_item.cross_z !== e.cross_z)
					$display("%0t cross_z exp %0d got %0d", $time, e.cross_z, out_item.cross_z);
				if (out_item.fraction !== e.fraction)
					$display("%0t fraction exp %0d got %0d", $time, e.fraction,
						out_item.fraction);
				if (out_item !== e)
					errors <= errors + 1;
			end
		end
	end

	// leaves in_valid high; drain() or an idle gap in the next send drops it
	task automatic send_query(input sti_in_t q);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= q;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_q.push_back(predict_crossing(q));
		items_sent++;
	endtask

	function automatic logic [47:0] pack_point(input int x, input int y, input int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic logic [47:0] rand_point(input int span);
		return pack_point($urandom_range(2*span) - span, $urandom_range(2*span) - span,
			$urandom_range(2*span) - span);
	endfunction

	// well-formed query: random triangle, plane with normal mostly along a random axis
	function automatic sti_in_t shaped_query(input int span);
		sti_in_t q;
		int ax, dv, nv, o0, o1;
		logic [15:0] nrm[3];
		q.start_point = rand_point(span);
		q.end_point = rand_point(span);
		q.vertex_a = rand_point(span);
		q.vertex_b = rand_point(span);
		q.vertex_c = rand_point(span);
		ax = $urandom_range(2);
		nv = $urandom_range(1) ? 4096 : -4096;
		for (int k = 0; k < 3; k++)
			nrm[k] = (k == ax) ? 16'(nv) : 16'($urandom_range(3000) - 1500);
		dv = $urandom_range(2*span) - span;
		q.plane_packed = {16'(dv), nrm[2], nrm[1], nrm[0]};
		// keep the segment straddling the plane most of the time
		if ($urandom_range(3) != 0) begin
			o0 = int'($urandom_range(span)) + 1;
			o1 = int'($urandom_range(span)) + 1;
			q.start_point[ax*16 +: 16] = 16'(dv + o0 * nv / 4096);
			q.end_point[ax*16 +: 16] = 16'(dv - o1 * nv / 4096);
		end
		return q;
	endfunction

	function automatic sti_in_t raw_query();
		sti_in_t q;
		logic [319:0] raw;
		raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()};
		q = raw[$bits(sti_in_t)-1:0];
		return q;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		sti_in_t q;
		logic [47:0] tri_a, tri_b, tri_c;
		tri_a = pack_point(-1000, -1000, 0);
		tri_b = pack_point(1000, -1000, 0);
		tri_c = pack_point(0, 1000, 0);
		// hit through the middle, plane z = 0
		q = {16'd0, 16'd4096, 16'd0, 16'd0, tri_c, tri_b, tri_a,
			pack_point(0, 0, -500), pack_point(0, 0, 500)};
		send_query(q);
		// crossing outside the triangle
		q.start_point = pack_point(5000, 5000, 500);
		q.end_point = pack_point(5000, 5000, -500);
		send_query(q);
		// same side
		q.end_point = pack_point(0, 0, 100);
		send_query(q);
		// segment in the plane
		q.start_point = pack_point(0, 0, 0);
		q.end_point = pack_point(100, 0, 0);
		send_query(q);
		// start point on the plane, end point on the plane only
		q.start_point = pack_point(10, 10, 0);
		q.end_point = pack_point(10, 10, 300);
		send_query(q);
		q.start_point = pack_point(10, 10, 300);
		q.end_point = pack_point(10, 10, 0);
		send_query(q);
		// no dominant axis
		q.plane_packed = {16'd0, 16'd2048, 16'd2048, 16'd2048};
		q.start_point = pack_point(-300, -300, -300);
		q.end_point = pack_point(300, 300, 300);
		send_query(q);
		// degenerate triangle
		q.vertex_a = pack_point(7, 7, 7);
		q.vertex_b = pack_point(7, 7, 7);
		q.vertex_c = pack_point(7, 7, 7);
		send_query(q);
		// unnormalized negative normal, extreme coordinates with saturation
		q = {16'h8000, 16'h8000, 16'h8000, 16'h8000, {3{pack_point(32767, -32768, 0)}},
			pack_point(-32768, -32768, -32768), pack_point(32767, 32767, 32767)};
		send_query(q);
		q = {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, tri_c, tri_b, tri_a,
			pack_point(32767, 32767, 32767), pack_point(-32768, -32768, -32768)};
		send_query(q);
		q = '1;
		send_query(q);
		q = '0;
		send_query(q);
		drain();
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: send_query(raw_query());
				1: send_query(shaped_query(32767));
				default: send_query(shaped_query(2000));
			endcase
		end
	endtask

	task automatic test_no_idle(input int count);
		idle_pct = 0;
		test_random(count);
		idle_pct = 28;
	endtask

	task automatic test_backpressure();
		hold_cycles = 200;
		test_random(150);
		drain();
		repeat ($urandom_range(20, 5)) @(posedge clk);
		test_random(50);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(700);
		test_no_idle(300);
		test_backpressure();
		test_random(500);
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d queries, %0d results checked, %0d hits", items_sent,
			results_seen, hits);
		$display("covered plane misses, in-plane, edge, saturation and stall cases");
		if (errors == 0)
			$display("segment_triangle_intersect_core_test: clean");
		else
			$display("segment_triangle_intersect_core_test: errors");
		$finish;
	end
endmodule
